/* hdl/frhs_pkg.sv */
// ----------------------------------------------------------------------------
// frhs_pkg: shared types and constants of the flow ratio smoother
// command and status words between controller and datapath, register map
// ----------------------------------------------------------------------------
package frhs_pkg;

    localparam int unsigned FLOW_W    = 12;
    localparam int unsigned RATIO_W   = 10;
    localparam int unsigned MEM_W     = 18;
    localparam int unsigned DIVD_W    = 24;
    localparam int unsigned DIV_STEPS = DIVD_W;
    localparam int unsigned CNT_W     = 5;

    localparam logic [RATIO_W-1:0] RATIO_MAX     = 10'd1000;
    localparam logic [7:0]         BAND_LIMIT    = 8'd100;
    localparam logic [7:0]         BYPASS_FACTOR = 8'd100;
    localparam logic [17:0]        GAIN_MUL      = 18'd640;
    localparam logic [17:0]        GAIN_ROUND    = 18'd125;
    // ceil(2^24 / 250), exact for every operand below 2^18
    localparam logic [35:0]        GAIN_RECIP    = 36'd67109;

    typedef enum logic [2:0] {
        CFG_FLOW_PERCENT   = 3'd0,
        CFG_FLOW_MAXIMUM   = 3'd1,
        CFG_HYST_WIDTH     = 3'd2,
        CFG_START_VALUE    = 3'd3,
        CFG_TIME_CONSTANT  = 3'd4,
        CFG_DELTA_LOW      = 3'd5,
        CFG_DELTA_HIGH     = 3'd6,
        CFG_WAIT_TICKS     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic hyst;
        logic mult;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

/* hdl/flow_ratio_hysteresis_smoother.sv */
// ----------------------------------------------------------------------------
// flow_ratio_hysteresis_smoother: fuel flow demand to smoothed per-mille ratio
// sequencing: one word at a time, each through the 24-step serial divider
// the next word is taken while the previous result waits in the output register
// reset: asynchronous, active low; registers to defaults, state and filter to zero
// ----------------------------------------------------------------------------
module flow_ratio_hysteresis_smoother
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // summed_flow[11:0], zero fill
    input  logic        s_tuser,   // filter_reset
    output logic        m_tvalid,
    input  logic        m_tready,
    // normalised_ratio[9:0], hysteresis_ratio[19:10], smoothed_ratio[29:20],
    // final_ratio[39:30]
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // raw_selected
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    frhs_pkg::cmd_t    cmd;
    frhs_pkg::status_t status;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    frhs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frhs_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .summed_flow      (s_tdata[11:0]),
        .filter_reset     (s_tuser),
        .cmd              (cmd),
        .status           (status),
        .normalised_ratio (m_tdata[9:0]),
        .hysteresis_ratio (m_tdata[19:10]),
        .smoothed_ratio   (m_tdata[29:20]),
        .raw_selected     (m_tuser),
        .final_ratio      (m_tdata[39:30])
    );

endmodule

/* hdl/frhs_ctrl.sv */
// ----------------------------------------------------------------------------
// frhs_ctrl: sequencer of the flow ratio smoother
// steps one word through product, serial divide, hysteresis, filter, commit
// ----------------------------------------------------------------------------
module frhs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  frhs_pkg::status_t status,
    output frhs_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_DIV    = 6'b000100,
        S_HYST   = 6'b001000,
        S_MULT   = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next   = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_HYST;
                end
            end
            S_HYST:
            begin
                cmd.hyst   = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the word
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/frhs_datapath.sv */
// ----------------------------------------------------------------------------
// frhs_datapath: arithmetic and state of the flow ratio smoother
// register file, restoring divider, hysteresis, low-pass filter, turn-on delay
// ----------------------------------------------------------------------------
module frhs_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [11:0]            summed_flow,
    input  logic                   filter_reset,
    input  frhs_pkg::cmd_t         cmd,
    output frhs_pkg::status_t      status,
    output logic [9:0]             normalised_ratio,
    output logic [9:0]             hysteresis_ratio,
    output logic [9:0]             smoothed_ratio,
    output logic                   raw_selected,
    output logic [9:0]             final_ratio
);

    // configuration
    logic [7:0]         flow_percent_reg;
    logic [15:0]        flow_maximum_reg;
    logic [7:0]         hysteresis_width_reg;
    logic [7:0]         filter_start_value_reg;
    logic [7:0]         time_constant_factor_reg;
    logic signed [15:0] delta_low_bound_reg;
    logic signed [15:0] delta_high_bound_reg;
    logic [15:0]        wait_ticks_reg;

    // per-word working registers
    logic               frst_reg,  frst_next;
    logic [19:0]        fp_reg,    fp_next;
    logic [17:0]        gx_reg,    gx_next;
    logic [7:0]         gain_reg,  gain_next;
    logic [23:0]        quo_reg,   quo_next;
    logic [16:0]        rem_reg,   rem_next;
    logic [4:0]         cnt_reg,   cnt_next;
    logic [9:0]         norm_reg,  norm_next;
    logic [9:0]         hyst_reg,  hyst_next;
    logic signed [27:0] prodf_reg, prodf_next;
    logic signed [15:0] d_reg,     d_next;

    // block state
    logic [9:0]         prev_ratio_reg, prev_ratio_next;
    logic [17:0]        mem_reg,        mem_next;
    logic               prev_cond_reg,  prev_cond_next;
    logic [15:0]        delay_reg,      delay_next;

    // result word
    logic [9:0]         o_norm_reg,   o_norm_next;
    logic [9:0]         o_hyst_reg,   o_hyst_next;
    logic [9:0]         o_smooth_reg, o_smooth_next;
    logic               o_sel_reg,    o_sel_next;
    logic [9:0]         o_final_reg,  o_final_next;

    logic [35:0]        gprod;
    logic [16:0]        rem_try;
    logic [6:0]         band_pct;
    logic [9:0]         band;
    logic [9:0]         norm_c;
    logic signed [11:0] lower;
    logic [10:0]        up_sum;
    logic [9:0]         hyst_c;
    logic signed [18:0] diff;
    logic signed [27:0] adj;
    logic signed [19:0] step;
    logic signed [20:0] m_sum;
    logic [17:0]        mem_f;
    logic [9:0]         smooth_c;
    logic               cond;
    logic               sel;
    logic [15:0]        dly_c;

    assign status.div_last = (cnt_reg == 5'(frhs_pkg::DIV_STEPS - 1));

    assign normalised_ratio = o_norm_reg;
    assign hysteresis_ratio = o_hyst_reg;
    assign smoothed_ratio   = o_smooth_reg;
    assign raw_selected     = o_sel_reg;
    assign final_ratio      = o_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_percent_reg         <= 8'd100;
            flow_maximum_reg         <= 16'd1000;
            hysteresis_width_reg     <= 8'd0;
            filter_start_value_reg   <= 8'd0;
            time_constant_factor_reg <= 8'd0;
            delta_low_bound_reg      <= 16'sd0;
            delta_high_bound_reg     <= 16'sd0;
            wait_ticks_reg           <= 16'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                frhs_pkg::CFG_FLOW_PERCENT:  flow_percent_reg         <= cfg_data[7:0];
                frhs_pkg::CFG_FLOW_MAXIMUM:  flow_maximum_reg         <= cfg_data;
                frhs_pkg::CFG_HYST_WIDTH:    hysteresis_width_reg     <= cfg_data[7:0];
                frhs_pkg::CFG_START_VALUE:   filter_start_value_reg   <= cfg_data[7:0];
                frhs_pkg::CFG_TIME_CONSTANT: time_constant_factor_reg <= cfg_data[7:0];
                frhs_pkg::CFG_DELTA_LOW:     delta_low_bound_reg      <= $signed(cfg_data);
                frhs_pkg::CFG_DELTA_HIGH:    delta_high_bound_reg     <= $signed(cfg_data);
                frhs_pkg::CFG_WAIT_TICKS:    wait_ticks_reg           <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // capture and product
    always_comb
    begin
        frst_next = frst_reg;
        fp_next   = fp_reg;
        gx_next   = gx_reg;
        if (cmd.capture)
        begin
            frst_next = filter_reset;
            fp_next   = 20'(summed_flow) * 20'(flow_percent_reg);
            gx_next   = 18'(time_constant_factor_reg) * frhs_pkg::GAIN_MUL
                        + frhs_pkg::GAIN_ROUND;
        end
    end

    // gain by reciprocal, dividend load and restoring divide
    assign gprod   = 36'(gx_reg) * frhs_pkg::GAIN_RECIP;
    assign rem_try = {rem_reg[15:0], quo_reg[23]};

    always_comb
    begin
        gain_next = gain_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        priority if (cmd.prep)
        begin
            gain_next = gprod[31:24];
            quo_next  = 24'({fp_reg, 3'b000}) + 24'({fp_reg, 1'b0});
            rem_next  = '0;
            cnt_next  = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (rem_try >= {1'b0, flow_maximum_reg})
            begin
                rem_next = rem_try - {1'b0, flow_maximum_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = rem_try;
                quo_next = {quo_reg[22:0], 1'b0};
            end
        end
    end

    // clamp and rise-through hysteresis
    always_comb
    begin
        norm_c   = (flow_maximum_reg == 16'd0 || quo_reg > 24'(frhs_pkg::RATIO_MAX))
                   ? frhs_pkg::RATIO_MAX : quo_reg[9:0];
        band_pct = (hysteresis_width_reg > frhs_pkg::BAND_LIMIT)
                   ? frhs_pkg::BAND_LIMIT[6:0] : hysteresis_width_reg[6:0];
        band     = 10'({band_pct, 3'b000}) + 10'({band_pct, 1'b0});
        lower    = $signed({2'b00, prev_ratio_reg}) - $signed({2'b00, band});
        up_sum   = 11'(norm_c) + 11'(band);
        priority if (norm_c > prev_ratio_reg)
        begin
            hyst_c = norm_c;
        end
        else if ($signed({2'b00, norm_c}) >= lower)
        begin
            hyst_c = prev_ratio_reg;
        end
        else if (up_sum > 11'(frhs_pkg::RATIO_MAX))
        begin
            hyst_c = frhs_pkg::RATIO_MAX;
        end
        else
        begin
            hyst_c = up_sum[9:0];
        end
        norm_next = cmd.hyst ? norm_c : norm_reg;
        hyst_next = cmd.hyst ? hyst_c : hyst_reg;
    end

    // filter product and tenfold ratio change
    assign diff = $signed({1'b0, hyst_reg, 8'b0}) - $signed({1'b0, mem_reg});

    always_comb
    begin
        prodf_next = prodf_reg;
        d_next     = d_reg;
        if (cmd.mult)
        begin
            prodf_next = $signed({1'b0, gain_reg}) * diff;
            d_next     = ($signed({6'b0, hyst_reg}) - $signed({6'b0, prev_ratio_reg}))
                         * 16'sd10;
        end
    end

    // commit: filter update, delay counter, result word
    always_comb
    begin
        // truncate toward zero on the divide by 256
        adj   = prodf_reg + $signed({20'b0, {8{prodf_reg[27]}}});
        step  = adj[27:8];
        m_sum = $signed({3'b000, mem_reg}) + $signed({step[19], step});
        mem_f = m_sum[20] ? 18'd0 : m_sum[17:0];

        priority if (frst_reg)
        begin
            smooth_c = 10'(filter_start_value_reg);
            mem_next = 18'({filter_start_value_reg, 8'b0});
        end
        else if (time_constant_factor_reg < frhs_pkg::BYPASS_FACTOR)
        begin
            smooth_c = (mem_f[17:8] > frhs_pkg::RATIO_MAX) ? frhs_pkg::RATIO_MAX
                                                           : mem_f[17:8];
            mem_next = mem_f;
        end
        else
        begin
            smooth_c = hyst_reg;
            mem_next = {hyst_reg, 8'b0};
        end

        cond = (d_reg > delta_low_bound_reg)
               || (d_reg < delta_low_bound_reg && d_reg >= delta_high_bound_reg);
        priority if (!cond)
        begin
            dly_c = delay_reg;
        end
        else if (!prev_cond_reg)
        begin
            dly_c = wait_ticks_reg;
        end
        else if (delay_reg != 16'd0)
        begin
            dly_c = delay_reg - 16'd1;
        end
        else
        begin
            dly_c = delay_reg;
        end
        sel = cond && (dly_c == 16'd0);

        if (!cmd.commit)
        begin
            mem_next = mem_reg;
        end
        prev_ratio_next = cmd.commit ? hyst_reg : prev_ratio_reg;
        prev_cond_next  = cmd.commit ? cond     : prev_cond_reg;
        delay_next      = cmd.commit ? dly_c    : delay_reg;
        o_norm_next     = cmd.commit ? norm_reg : o_norm_reg;
        o_hyst_next     = cmd.commit ? hyst_reg : o_hyst_reg;
        o_smooth_next   = cmd.commit ? smooth_c : o_smooth_reg;
        o_sel_next      = cmd.commit ? sel      : o_sel_reg;
        o_final_next    = cmd.commit ? (sel ? hyst_reg : smooth_c) : o_final_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            prev_ratio_reg <= '0;
            mem_reg        <= '0;
            prev_cond_reg  <= 1'b0;
            delay_reg      <= '0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            prev_ratio_reg <= prev_ratio_next;
            mem_reg        <= mem_next;
            prev_cond_reg  <= prev_cond_next;
            delay_reg      <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frst_reg     <= frst_next;
        fp_reg       <= fp_next;
        gx_reg       <= gx_next;
        gain_reg     <= gain_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        norm_reg     <= norm_next;
        hyst_reg     <= hyst_next;
        prodf_reg    <= prodf_next;
        d_reg        <= d_next;
        o_norm_reg   <= o_norm_next;
        o_hyst_reg   <= o_hyst_next;
        o_smooth_reg <= o_smooth_next;
        o_sel_reg    <= o_sel_next;
        o_final_reg  <= o_final_next;
    end

endmodule

/* hdl/frhs_checker.sv */
// ----------------------------------------------------------------------------
// frhs_checker: port-level checks of the flow ratio smoother
// sequencing, result hold, ratio range and final selection
// ----------------------------------------------------------------------------
module frhs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // one word at a time: after a word is taken the input closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after a word was taken");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9:0] <= frhs_pkg::RATIO_MAX
                     && m_tdata[19:10] <= frhs_pkg::RATIO_MAX
                     && m_tdata[39:30] <= frhs_pkg::RATIO_MAX)
        else $error("ratio above full scale");

    a_final_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser ? m_tdata[39:30] == m_tdata[19:10]
                              : m_tdata[39:30] == m_tdata[29:20]))
        else $error("final ratio does not follow the selection flag");

endmodule

bind flow_ratio_hysteresis_smoother frhs_checker u_frhs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
